// ===== rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 16;
  localparam int DimRegBits  = 13;
  localparam int IterBits    = 16;
  localparam int IntenBits   = 8;

  localparam logic [CfgIdxBits-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_MAXIT  = 2'd2;

  localparam logic [DimRegBits-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DimRegBits-1:0] HEIGHT_RST = 13'd480;
  localparam logic [IterBits-1:0]   MAXIT_RST  = 16'd255;

  typedef enum logic [1:0] {
    MS_NONE,
    MS_RR,
    MS_II,
    MS_RI
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_MRR,
    ST_MII,
    ST_MRI,
    ST_CRI,
    ST_TEST,
    ST_IDIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic     div_start;
    logic     ld_c;
    mul_sel_e mul;
    mul_sel_e comb;
    logic     upd;
    logic     int_start;
    logic     set_esc;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic int_busy;
    logic esc_hit;
    logic cnt_zero;
    logic cnt_max;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/mbe_div.sv =====
// ----------------------------------------------------------------------------
// mbe_div
// Restoring divider, one quotient bit per cycle, low quotient bits kept.
// ----------------------------------------------------------------------------
module mbe_div #(
  parameter int N_W = 24,
  parameter int D_W = 16,
  parameter int Q_W = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           busy_o,
  output logic [Q_W-1:0] quot_o
);

  localparam int CW = $clog2(N_W + 1);

  logic [N_W-1:0] num_q, num_d;
  logic [D_W-1:0] rem_q, rem_d, den_q;
  logic [Q_W-1:0] quot_q, quot_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic [D_W:0]   trial;
  logic           ge;

  assign trial = {rem_q, num_q[N_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = CW'(N_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d  = num_q << 1;
      rem_d  = ge ? D_W'(trial - {1'b0, den_q}) : D_W'(trial);
      quot_d = {quot_q[Q_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      busy_d = cnt_q != CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) den_q <= divisor_i;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/mbe_datapath.sv =====
// ----------------------------------------------------------------------------
// mbe_datapath
// Config registers, coordinate mapping, split multiplier, iterate, intensity and result.
// ----------------------------------------------------------------------------
module mbe_datapath import mbe_pkg::*; #(
  parameter int DIM_BITS  = 12,
  parameter int FRAC_BITS = 28
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic [DIM_BITS-1:0]   pixel_col_i,
  input  logic [DIM_BITS-1:0]   pixel_row_i,
  input  cmd_t                  cmd_i,
  output status_t               st_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [IntenBits-1:0]  intensity_o,
  output logic [IterBits-1:0]   iter_count_o,
  output logic                  escaped_o
);

  localparam int W   = FRAC_BITS + 4;
  localparam int HB  = (W + 1) / 2;
  localparam int PW  = 2 * W;
  localparam int NRE = DIM_BITS + 2 + FRAC_BITS;
  localparam int NIM = DIM_BITS + 3 + FRAC_BITS;
  localparam logic [W-1:0]  CRE_OFS = W'(64'd2 << FRAC_BITS);
  localparam logic [W-1:0]  CIM_OFS = W'(64'd7 << (FRAC_BITS - 2));
  localparam logic [PW:0]   ESC_LIM = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [DimRegBits-1:0] width_q, height_q;
  logic [IterBits-1:0]   maxit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      maxit_q  <= MAXIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[DimRegBits-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DimRegBits-1:0];
        CFG_MAXIT:  maxit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // coordinate mapping dividers
  logic [DIM_BITS+1:0]   col3;
  logic [DIM_BITS+2:0]   row7;
  logic [DimRegBits-1:0] wdiv;
  logic [DimRegBits:0]   hdiv;
  logic [W-1:0]          qre, qim;
  logic                  busy_re, busy_im, busy_int;

  assign col3 = {2'b0, pixel_col_i} + {1'b0, pixel_col_i, 1'b0};
  assign row7 = {pixel_row_i, 3'b0} - {3'b0, pixel_row_i};
  assign wdiv = (width_q == '0) ? DimRegBits'(1) : width_q;
  assign hdiv = (height_q == '0) ? (DimRegBits + 1)'(2) : {height_q, 1'b0};

  mbe_div #(.N_W(NRE), .D_W(DimRegBits), .Q_W(W)) u_div_re (
    .clk_i, .rst_ni,
    .start_i    (cmd_i.div_start),
    .dividend_i ({col3, {FRAC_BITS{1'b0}}}),
    .divisor_i  (wdiv),
    .busy_o     (busy_re),
    .quot_o     (qre)
  );

  mbe_div #(.N_W(NIM), .D_W(DimRegBits + 1), .Q_W(W)) u_div_im (
    .clk_i, .rst_ni,
    .start_i    (cmd_i.div_start),
    .dividend_i ({row7, {FRAC_BITS{1'b0}}}),
    .divisor_i  (hdiv),
    .busy_o     (busy_im),
    .quot_o     (qim)
  );

  // iterate state
  logic [W-1:0]        cre_q, cim_q, re_q, im_q, mre_q, mim_q;
  logic [IterBits-1:0] count_q;
  logic                esc_q;
  logic [W-1:0]        opa, opb;
  logic [2*HB-1:0]     pp00_q, pp01_q, pp10_q, pp11_q;
  logic [PW-1:0]       prod, rr_q, ii_q, ri_q;
  logic [PW:0]         sq_sum, ri_s;
  logic [W-1:0]        rr_f, ii_f, ri_f, new_re, new_im, cre, cim;

  always_comb begin
    opa = mre_q;
    opb = mre_q;
    case (cmd_i.mul)
      MS_II:   begin opa = mim_q; opb = mim_q; end
      MS_RI:   opb = mim_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pp00_q <= (2 * HB)'(opa[HB-1:0]) * (2 * HB)'(opb[HB-1:0]);
    pp01_q <= (2 * HB)'(opa[HB-1:0]) * (2 * HB)'(HB'(opb >> HB));
    pp10_q <= (2 * HB)'(HB'(opa >> HB)) * (2 * HB)'(opb[HB-1:0]);
    pp11_q <= (2 * HB)'(HB'(opa >> HB)) * (2 * HB)'(HB'(opb >> HB));
  end

  assign prod = (PW'(pp11_q) << (2 * HB)) + ((PW'(pp01_q) + PW'(pp10_q)) << HB)
              + PW'(pp00_q);

  always_ff @(posedge clk_i) begin
    case (cmd_i.comb)
      MS_RR:   rr_q <= prod;
      MS_II:   ii_q <= prod;
      MS_RI:   ri_q <= prod;
      default: ;
    endcase
  end

  assign sq_sum = {1'b0, rr_q} + {1'b0, ii_q};
  assign ri_s   = (re_q[W-1] ^ im_q[W-1]) ? (~{1'b0, ri_q} + 1'b1) : {1'b0, ri_q};
  assign rr_f   = rr_q[FRAC_BITS+W-1:FRAC_BITS];
  assign ii_f   = ii_q[FRAC_BITS+W-1:FRAC_BITS];
  assign ri_f   = ri_s[FRAC_BITS+W-2:FRAC_BITS-1];
  assign new_re = rr_f - ii_f + cre_q;
  assign new_im = ri_f + cim_q;
  assign cre    = qre - CRE_OFS;
  assign cim    = qim - CIM_OFS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_c) begin
      cre_q <= cre;
      cim_q <= cim;
      re_q  <= cre;
      im_q  <= cim;
      mre_q <= mag(cre);
      mim_q <= mag(cim);
    end else if (cmd_i.upd) begin
      re_q  <= new_re;
      im_q  <= new_im;
      mre_q <= mag(new_re);
      mim_q <= mag(new_im);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      esc_q   <= 1'b0;
    end else if (cmd_i.ld_c) begin
      count_q <= '0;
      esc_q   <= 1'b0;
    end else begin
      if (cmd_i.upd) count_q <= count_q + 1'b1;
      if (cmd_i.set_esc) esc_q <= 1'b1;
    end
  end

  // intensity divider
  logic [IntenBits-1:0] qint;

  mbe_div #(.N_W(IterBits + IntenBits), .D_W(IterBits), .Q_W(IntenBits)) u_div_int (
    .clk_i, .rst_ni,
    .start_i    (cmd_i.int_start),
    .dividend_i ({count_q, {IntenBits{1'b0}}} - {{IntenBits{1'b0}}, count_q}),
    .divisor_i  (maxit_q),
    .busy_o     (busy_int),
    .quot_o     (qint)
  );

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      intensity_o  <= esc_q ? qint : '0;
      iter_count_o <= esc_q ? count_q : '0;
      escaped_o    <= esc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign st_o.div_busy  = busy_re | busy_im;
  assign st_o.int_busy  = busy_int;
  assign st_o.esc_hit   = sq_sum > ESC_LIM;
  assign st_o.cnt_zero  = count_q == '0;
  assign st_o.cnt_max   = count_q == maxit_q;
  assign st_o.out_free  = !out_valid_q || !out_stall_i;

  a_res_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |=> out_valid_q) else $error("result not presented");
  a_upd_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |-> !st_o.cnt_max) else $error("iteration past limit");
  a_ld_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_c |-> !st_o.div_busy) else $error("c loaded before mapping done");

endmodule

// ===== rtl/mbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: mapping, multiply phases, escape test, intensity, result.
// ----------------------------------------------------------------------------
module mbe_ctrl import mbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DIV;
      ST_DIV:  if (!st_i.div_busy) state_d = ST_MRR;
      ST_MRR:  state_d = ST_MII;
      ST_MII:  state_d = ST_MRI;
      ST_MRI:  state_d = ST_CRI;
      ST_CRI:  state_d = ST_TEST;
      ST_TEST: begin
        if (!st_i.cnt_zero && st_i.esc_hit) state_d = ST_IDIV;
        else if (st_i.cnt_max)              state_d = ST_DONE;
        else                                state_d = ST_MRR;
      end
      ST_IDIV: if (!st_i.int_busy) state_d = ST_DONE;
      ST_DONE: if (st_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{div_start: 1'b0, ld_c: 1'b0, mul: MS_NONE, comb: MS_NONE, upd: 1'b0,
              int_start: 1'b0, set_esc: 1'b0, res_load: 1'b0};
    unique case (state_q)
      ST_IDLE: cmd_o.div_start = in_valid_i;
      ST_DIV:  cmd_o.ld_c = !st_i.div_busy;
      ST_MRR:  cmd_o.mul = MS_RR;
      ST_MII:  begin cmd_o.mul = MS_II; cmd_o.comb = MS_RR; end
      ST_MRI:  begin cmd_o.mul = MS_RI; cmd_o.comb = MS_II; end
      ST_CRI:  cmd_o.comb = MS_RI;
      ST_TEST: begin
        if (!st_i.cnt_zero && st_i.esc_hit) begin
          cmd_o.int_start = 1'b1;
          cmd_o.set_esc   = 1'b1;
        end else if (!st_i.cnt_max) begin
          cmd_o.upd = 1'b1;
        end
      end
      ST_IDIV: ;
      ST_DONE: cmd_o.res_load = st_i.out_free;
      default: ;
    endcase
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule

// ===== rtl/mandelbrot_escape_pixel_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top
// Escape-time evaluator for one pixel per transfer.
// The coordinates are mapped by bit-serial division, then each iterate runs
// three split multiplies, a combine and a test/update, over count+1 passes,
// followed by the intensity division when the pixel escapes and the load
// into the output register.
// One pixel at a time; the next is taken while a result waits.
// Reset clears control and sets the registers to 640, 480 and 255.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top import mbe_pkg::*; #(
  parameter int DIM_BITS  = 12,
  parameter int FRAC_BITS = 28
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [DIM_BITS-1:0]    pixel_col_i,
  input  logic [DIM_BITS-1:0]    pixel_row_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [IntenBits-1:0]   intensity_o,
  output logic [IterBits-1:0]    iter_count_o,
  output logic                   escaped_o
);

  cmd_t    cmd;
  status_t st;

  mbe_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .st_i  (st),
    .cmd_o (cmd)
  );

  mbe_datapath #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pixel_col_i, .pixel_row_i,
    .cmd_i (cmd),
    .st_o  (st),
    .out_stall_i,
    .out_valid_o,
    .intensity_o,
    .iter_count_o,
    .escaped_o
  );

endmodule

// ===== verif/mandelbrot_escape_pixel_top_tb.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top_tb
// Self-checking bench for the escape-time pixel evaluator: a bit-exact
// predictor in the scoreboard, directed corners, then randomised phases over
// several image sizes and iteration limits with random idling on both sides.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top_tb;
  import mbe_pkg::*;

  localparam int DimBits  = 12;
  localparam int FracBits = 28;
  localparam int WordBits = FracBits + 4;
  localparam int IdleLimit = 1500000;
  localparam logic [CfgIdxBits-1:0] CfgUnused = 2'd3;

  typedef logic [WordBits-1:0] word_t;

  typedef struct {
    logic [IntenBits-1:0] intensity;
    logic [IterBits-1:0]  iter_count;
    logic                 escaped;
  } pixel_res_t;

  class escape_scoreboard;
    logic [DimRegBits-1:0] width_q, height_q;
    logic [IterBits-1:0]   maxit_q;
    pixel_res_t            pending[$];
    int                    errors;
    int                    checked;
    int                    escapes;

    function new();
      width_q  = WIDTH_RST;
      height_q = HEIGHT_RST;
      maxit_q  = MAXIT_RST;
      errors   = 0;
      checked  = 0;
      escapes  = 0;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
      case (idx)
        CFG_WIDTH:  width_q  = val[DimRegBits-1:0];
        CFG_HEIGHT: height_q = val[DimRegBits-1:0];
        CFG_MAXIT:  maxit_q  = val[IterBits-1:0];
        default: ;
      endcase
    endfunction

    function word_t fmul(word_t a, word_t b, int sh);
      longint signed p;
      p = longint'(signed'(a)) * longint'(signed'(b));
      return word_t'(p >>> sh);
    endfunction

    function logic beyond_four(word_t a, word_t b);
      longint signed pa, pb;
      logic [64:0]   s;
      pa = longint'(signed'(a)) * longint'(signed'(a));
      pb = longint'(signed'(b)) * longint'(signed'(b));
      s  = {1'b0, pa} + {1'b0, pb};
      return s > (65'd1 << (2 * FracBits + 2));
    endfunction

    function void note_pixel(logic [DimBits-1:0] col, logic [DimBits-1:0] row);
      longint unsigned w, h;
      word_t      c_re, c_im, re, im, nre;
      pixel_res_t r;
      int         k;
      w    = (width_q == 0) ? 1 : width_q;
      h    = (height_q == 0) ? 1 : height_q;
      c_re = word_t'(((longint'(col) * 3) << FracBits) / w) - (word_t'(2) << FracBits);
      c_im = word_t'(((longint'(row) * 7) << FracBits) / (2 * h))
           - (word_t'(7) << (FracBits - 2));
      re   = c_re;
      im   = c_im;
      r.intensity  = '0;
      r.iter_count = '0;
      r.escaped    = 1'b0;
      for (k = 1; k <= maxit_q; k++) begin
        nre = fmul(re, re, FracBits) - fmul(im, im, FracBits) + c_re;
        im  = fmul(re, im, FracBits - 1) + c_im;
        re  = nre;
        if (beyond_four(re, im)) begin
          r.escaped    = 1'b1;
          r.iter_count = k[IterBits-1:0];
          r.intensity  = IntenBits'((k * 255) / maxit_q);
          break;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_pixel(logic [IntenBits-1:0] inten, logic [IterBits-1:0] cnt,
                              logic esc);
      pixel_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transfer intensity=%0d count=%0d escaped=%0b",
                 $time, inten, cnt, esc);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (esc) escapes++;
      if (inten !== e.intensity) begin
        $display("%0t: intensity expected %0d actual %0d", $time, e.intensity, inten);
        errors++;
      end
      if (cnt !== e.iter_count) begin
        $display("%0t: iter_count expected %0d actual %0d", $time, e.iter_count, cnt);
        errors++;
      end
      if (esc !== e.escaped) begin
        $display("%0t: escaped expected %0b actual %0b", $time, e.escaped, esc);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i, rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  logic                   in_valid_i, in_stall_o;
  logic [DimBits-1:0]     pixel_col_i, pixel_row_i;
  logic                   out_valid_o, out_stall_i;
  logic [IntenBits-1:0]   intensity_o;
  logic [IterBits-1:0]    iter_count_o;
  logic                   escaped_o;

  escape_scoreboard sb;
  int  idle_cycles = 0;
  int  long_hold;
  int  sent;

  mandelbrot_escape_pixel_top #(
    .DIM_BITS (DimBits),
    .FRAC_BITS(FracBits)
  ) u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .pixel_col_i, .pixel_row_i,
    .out_valid_o, .out_stall_i, .intensity_o, .iter_count_o, .escaped_o
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", IdleLimit);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int n;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      n = (long_hold != 0) ? 600 : $urandom_range(0, 10);
      if (long_hold != 0) long_hold = 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_pixel(intensity_o, iter_count_o, escaped_o);
    end
  end

  task automatic cfg_write(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic setup(int w, int h, int mi);
    drain();
    cfg_write(CFG_WIDTH, w[CfgDataBits-1:0]);
    cfg_write(CFG_HEIGHT, h[CfgDataBits-1:0]);
    cfg_write(CFG_MAXIT, mi[CfgDataBits-1:0]);
  endtask

  task automatic send_pixel(logic [DimBits-1:0] col, logic [DimBits-1:0] row);
    int gap;
    gap = $urandom_range(0, 10);
    if (sent % 200 < 30) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(col, row);
    sent++;
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int w, h, mi, cnt;
    sb = new();
    long_hold   = 0;
    sent        = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    pixel_col_i = '0;
    pixel_row_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    send_pixel(0, 0);
    send_pixel(639, 479);
    send_pixel(320, 240);
    send_pixel(4095, 4095);
    send_pixel(160, 300);
    idle_input();
    // zero width and height act as one, unused index ignored
    setup(0, 0, 1);
    cfg_write(CfgUnused, 16'hFFFF);
    send_pixel(0, 0);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(4095, 4095);
    idle_input();
    // largest image, zero limit
    setup(4096, 4096, 0);
    send_pixel(2048, 2048);
    send_pixel(4095, 0);
    idle_input();
    setup(8191, 8191, 16'hFFFF);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    idle_input();
    // c = 0 never escapes: runs the full limit
    setup(3, 2, 65535);
    send_pixel(2, 1);
    send_pixel(4095, 4095);
    idle_input();

    for (int p = 0; p < 9; p++) begin
      case (p % 3)
        0: w = $urandom_range(1, 700);
        1: w = $urandom_range(1, 4096);
        default: w = $urandom_range(1, 64);
      endcase
      h  = $urandom_range(1, (p % 2) ? 4096 : 600);
      mi = (p == 4) ? 255 : $urandom_range(1, 48);
      cnt = (p == 4) ? 40 : 150;
      if (p == 8) begin
        w  = $urandom_range(0, 65535);
        h  = $urandom_range(0, 65535);
      end
      setup(w, h, mi);
      for (int i = 0; i < cnt; i++) begin
        if (p == 2 && i == 20) long_hold = 1;
        if (i == cnt / 2) begin
          idle_input();
          drain();
        end
        if ($urandom_range(0, 9) < 8) begin
          send_pixel(DimBits'($urandom_range(0, ((w % 8192) > 0 ? (w % 8192) : 1) - 1)),
                     DimBits'($urandom_range(0, ((h % 8192) > 0 ? (h % 8192) : 1) - 1)));
        end else begin
          send_pixel(DimBits'($urandom()), DimBits'($urandom()));
        end
      end
      idle_input();
    end

    drain();
    $display("covered %0d pixels, %0d escaped, over reset, degenerate and random settings",
             sb.checked, sb.escapes);
    $display("%0d mismatches, %0d results still pending", sb.errors, sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mbe_pkg.sv
rtl/mbe_div.sv
rtl/mbe_datapath.sv
rtl/mbe_ctrl.sv
rtl/mandelbrot_escape_pixel_top.sv
verif/mandelbrot_escape_pixel_top_tb.sv
